/* rtl/core/prot_pkg.sv */
// Shared constants, types and the arctangent table for the point rotation unit.
package prot_pkg;

	// Field widths
	localparam int COORD_WIDTH  = 16;
	localparam int ANGLE_WIDTH  = 18;
	localparam int CORDIC_STEPS = 18;

	// Angle formats: input angle has 8 fraction bits, CORDIC angle has 22
	localparam int ANG_FRAC  = 8;
	localparam int Z_FRAC    = 22;
	localparam int HALF_TURN = 180;
	localparam int ANG_W     = ANGLE_WIDTH + 1;
	localparam int FULL_ANG  = 2 * HALF_TURN * (1 << ANG_FRAC);
	localparam int HALF_ANG  = HALF_TURN * (1 << ANG_FRAC);
	localparam int QUART_ANG = HALF_ANG / 2;
	localparam int Z_W       = 32;

	// CORDIC vector: Q30, start vector carries the inverse gain
	localparam int VEC_FRAC = 30;
	localparam int VEC_W    = 32;
	localparam logic signed [VEC_W-1:0] GAIN_Q30 = 32'sd652032874;

	// Product and sum widths for the final transform
	localparam int PROD_W = COORD_WIDTH + VEC_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int QUOT_W = SUM_W - VEC_FRAC;

	// Payload that travels beside the CORDIC vector
	typedef struct packed {
		logic                          flip;
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
	} prot_tag_t;

	// atan(2^-i) in degrees, Q22, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q22(input int unsigned i);
		logic signed [Z_W-1:0] v;
		case (i)
			0:  v = 32'sd188743680;
			1:  v = 32'sd111421900;
			2:  v = 32'sd58872272;
			3:  v = 32'sd29884485;
			4:  v = 32'sd15000234;
			5:  v = 32'sd7507429;
			6:  v = 32'sd3754631;
			7:  v = 32'sd1877430;
			8:  v = 32'sd938729;
			9:  v = 32'sd469366;
			10: v = 32'sd234683;
			11: v = 32'sd117342;
			12: v = 32'sd58671;
			13: v = 32'sd29335;
			14: v = 32'sd14668;
			15: v = 32'sd7334;
			16: v = 32'sd3667;
			17: v = 32'sd1833;
			18: v = 32'sd917;
			19: v = 32'sd458;
			20: v = 32'sd229;
			21: v = 32'sd115;
			22: v = 32'sd57;
			23: v = 32'sd29;
			24: v = 32'sd14;
			25: v = 32'sd7;
			26: v = 32'sd4;
			27: v = 32'sd2;
			28: v = 32'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/prot_cordic.sv */
// Pipelined CORDIC in rotation mode: one micro-rotation per register stage.
module prot_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   vld_in,
	input  logic signed [prot_pkg::Z_W-1:0]        z_in,
	input  prot_pkg::prot_tag_t                    tag_in,
	output logic                                   vld_out,
	output logic signed [prot_pkg::VEC_W-1:0]      cos_out,
	output logic signed [prot_pkg::VEC_W-1:0]      sin_out,
	output prot_pkg::prot_tag_t                    tag_out
);
	import prot_pkg::*;

	logic                    vld_s2 [CORDIC_STEPS];
	logic signed [VEC_W-1:0] cx_s2  [CORDIC_STEPS];
	logic signed [VEC_W-1:0] cy_s2  [CORDIC_STEPS];
	logic signed [Z_W-1:0]   z_s2   [CORDIC_STEPS];
	prot_tag_t               tag_s2 [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic                    vld_p;
		logic signed [VEC_W-1:0] cx_p;
		logic signed [VEC_W-1:0] cy_p;
		logic signed [Z_W-1:0]   z_p;
		prot_tag_t               tag_p;
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;
		logic signed [Z_W-1:0]   ang;

		// Select the previous stage, or the start vector for the first step
		if (k == 0) begin : g_first
			assign vld_p = vld_in;
			assign cx_p  = GAIN_Q30;
			assign cy_p  = '0;
			assign z_p   = z_in;
			assign tag_p = tag_in;
		end else begin : g_next
			assign vld_p = vld_s2[k-1];
			assign cx_p  = cx_s2[k-1];
			assign cy_p  = cy_s2[k-1];
			assign z_p   = z_s2[k-1];
			assign tag_p = tag_s2[k-1];
		end

		// Shift by the step index; arithmetic shift rounds toward minus infinity
		assign dx  = cy_p >>> k;
		assign dy  = cx_p >>> k;
		assign ang = atan_q22(k);

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (en) begin
				vld_s2[k] <= vld_p;
			end
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				tag_s2[k] <= tag_p;
				if (!z_p[Z_W-1]) begin
					cx_s2[k] <= cx_p - dx;
					cy_s2[k] <= cy_p + dy;
					z_s2[k]  <= z_p - ang;
				end else begin
					cx_s2[k] <= cx_p + dx;
					cy_s2[k] <= cy_p - dy;
					z_s2[k]  <= z_p + ang;
				end
			end
		end
	end

	assign vld_out = vld_s2[CORDIC_STEPS-1];
	assign cos_out = cx_s2[CORDIC_STEPS-1];
	assign sin_out = cy_s2[CORDIC_STEPS-1];
	assign tag_out = tag_s2[CORDIC_STEPS-1];

endmodule

/* rtl/core/point_rotation_by_angle_unit.sv */
// Top level of the point rotation unit: angle reduction, CORDIC, transform, saturation.
//
// Usage:
//   The point channel (point_valid / point_stall) carries point_x, point_y and
//   angle_deg (degrees, 8 fraction bits). The result channel (result_valid /
//   result_stall) carries rotated_x, rotated_y and saturated. A transaction
//   completes on a rising edge with valid high and stall low.
//   Every point gives exactly one result, in order.
//   The path from a taken point to result_valid has 24 register stages: one
//   CORDIC micro-rotation per stage plus angle reduction, sign fold, product,
//   sum, truncation and output stages.
//   Throughput: one point per cycle while the receiver takes results.
//   Stall: when result_stall holds a waiting result, one more result is
//   parked in a skid register; then point_stall rises and the whole
//   pipeline freezes until the output drains. Nothing is dropped or repeated.
//   Reset (arst_n low) empties the pipeline: result_valid and point_stall
//   go low. The block keeps no state between points.
module point_rotation_by_angle_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     point_valid,
	output logic                                     point_stall,
	input  logic signed [prot_pkg::COORD_WIDTH-1:0]  point_x,
	input  logic signed [prot_pkg::COORD_WIDTH-1:0]  point_y,
	input  logic signed [prot_pkg::ANGLE_WIDTH-1:0]  angle_deg,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic signed [prot_pkg::COORD_WIDTH-1:0]  rotated_x,
	output logic signed [prot_pkg::COORD_WIDTH-1:0]  rotated_y,
	output logic                                     saturated
);
	import prot_pkg::*;

	localparam logic signed [ANG_W-1:0]  FULL_A  = ANG_W'(FULL_ANG);
	localparam logic signed [ANG_W-1:0]  HALF_A  = ANG_W'(HALF_ANG);
	localparam logic signed [ANG_W-1:0]  QUART_A = ANG_W'(QUART_ANG);
	localparam logic signed [QUOT_W-1:0] SAT_HI  = QUOT_W'((1 << (COORD_WIDTH - 1)) - 1);
	localparam logic signed [QUOT_W-1:0] SAT_LO  = -SAT_HI - QUOT_W'(1);
	localparam logic signed [COORD_WIDTH-1:0] OUT_HI = SAT_HI[COORD_WIDTH-1:0];
	localparam logic signed [COORD_WIDTH-1:0] OUT_LO = SAT_LO[COORD_WIDTH-1:0];

	logic en;

	// Stage 1: angle reduction and quadrant fold
	logic signed [ANG_W-1:0] a_wrap;
	logic signed [ANG_W-1:0] a_fold;
	logic                    flip_c;

	logic                    vld_s1;
	logic signed [Z_W-1:0]   z_s1;
	prot_tag_t               tag_s1;

	// After the CORDIC
	logic                    vld_c;
	logic signed [VEC_W-1:0] cos_c;
	logic signed [VEC_W-1:0] sin_c;
	prot_tag_t               tag_c;

	logic                          vld_s3;
	logic signed [VEC_W-1:0]       cos_s3;
	logic signed [VEC_W-1:0]       sin_s3;
	logic signed [COORD_WIDTH-1:0] px_s3;
	logic signed [COORD_WIDTH-1:0] py_s3;

	logic                     vld_s4;
	logic signed [PROD_W-1:0] pxc_s4;
	logic signed [PROD_W-1:0] pys_s4;
	logic signed [PROD_W-1:0] pxs_s4;
	logic signed [PROD_W-1:0] pyc_s4;

	logic                    vld_s5;
	logic signed [SUM_W-1:0] rx_s5;
	logic signed [SUM_W-1:0] ry_s5;

	logic signed [SUM_W-1:0] rx_adj;
	logic signed [SUM_W-1:0] ry_adj;

	logic                     vld_s6;
	logic signed [QUOT_W-1:0] qx_s6;
	logic signed [QUOT_W-1:0] qy_s6;

	logic signed [COORD_WIDTH-1:0] sx_c;
	logic signed [COORD_WIDTH-1:0] sy_c;
	logic                          sat_c;

	logic                          skid_vld_q;
	logic signed [COORD_WIDTH-1:0] skid_x_q;
	logic signed [COORD_WIDTH-1:0] skid_y_q;
	logic                          skid_sat_q;

	logic                          out_vld_q;
	logic signed [COORD_WIDTH-1:0] out_x_q;
	logic signed [COORD_WIDTH-1:0] out_y_q;
	logic                          out_sat_q;

	// Freeze the pipeline while the skid register holds a result
	assign en          = !skid_vld_q;
	assign point_stall = skid_vld_q;

	// Wrap into (-180, 180], then fold into [-90, 90] and mark the negation
	always_comb begin
		a_wrap = ANG_W'(angle_deg);
		if (a_wrap > HALF_A) begin
			a_wrap = a_wrap - FULL_A;
		end else if (a_wrap <= -HALF_A) begin
			a_wrap = a_wrap + FULL_A;
		end
		a_fold = a_wrap;
		flip_c = 1'b0;
		if (a_wrap > QUART_A) begin
			a_fold = a_wrap - HALF_A;
			flip_c = 1'b1;
		end else if (a_wrap < -QUART_A) begin
			a_fold = a_wrap + HALF_A;
			flip_c = 1'b1;
		end
	end

	// Valid bits for the stages outside the CORDIC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point_valid;
			vld_s3 <= vld_c;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 1 payload: angle to Q22
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1        <= Z_W'(a_fold) <<< (Z_FRAC - ANG_FRAC);
			tag_s1.flip <= flip_c;
			tag_s1.px   <= point_x;
			tag_s1.py   <= point_y;
		end
	end

	prot_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s1),
		.z_in    (z_s1),
		.tag_in  (tag_s1),
		.vld_out (vld_c),
		.cos_out (cos_c),
		.sin_out (sin_c),
		.tag_out (tag_c)
	);

	// Round the residual transform: truncate toward zero by biasing negatives
	assign rx_adj = rx_s5 + SUM_W'({VEC_FRAC{rx_s5[SUM_W-1]}});
	assign ry_adj = ry_s5 + SUM_W'({VEC_FRAC{ry_s5[SUM_W-1]}});

	// Stages 3 to 6: negate, multiply, sum, truncate
	always_ff @(posedge clk) begin
		if (en) begin
			cos_s3 <= tag_c.flip ? -cos_c : cos_c;
			sin_s3 <= tag_c.flip ? -sin_c : sin_c;
			px_s3  <= tag_c.px;
			py_s3  <= tag_c.py;

			pxc_s4 <= PROD_W'(px_s3) * PROD_W'(cos_s3);
			pys_s4 <= PROD_W'(py_s3) * PROD_W'(sin_s3);
			pxs_s4 <= PROD_W'(px_s3) * PROD_W'(sin_s3);
			pyc_s4 <= PROD_W'(py_s3) * PROD_W'(cos_s3);

			rx_s5 <= SUM_W'(pxc_s4) - SUM_W'(pys_s4);
			ry_s5 <= SUM_W'(pxs_s4) + SUM_W'(pyc_s4);

			qx_s6 <= rx_adj[SUM_W-1:VEC_FRAC];
			qy_s6 <= ry_adj[SUM_W-1:VEC_FRAC];
		end
	end

	// Clamp to the coordinate range and flag clipping
	always_comb begin
		sat_c = 1'b0;
		if (qx_s6 > SAT_HI) begin
			sx_c  = OUT_HI;
			sat_c = 1'b1;
		end else if (qx_s6 < SAT_LO) begin
			sx_c  = OUT_LO;
			sat_c = 1'b1;
		end else begin
			sx_c = qx_s6[COORD_WIDTH-1:0];
		end
		if (qy_s6 > SAT_HI) begin
			sy_c  = OUT_HI;
			sat_c = 1'b1;
		end else if (qy_s6 < SAT_LO) begin
			sy_c  = OUT_LO;
			sat_c = 1'b1;
		end else begin
			sy_c = qy_s6[COORD_WIDTH-1:0];
		end
	end

	// Output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			if (out_vld_q && result_stall) begin
				skid_vld_q <= vld_s6;
			end else begin
				out_vld_q <= vld_s6;
			end
		end else if (!result_stall) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			if (out_vld_q && result_stall) begin
				skid_x_q   <= sx_c;
				skid_y_q   <= sy_c;
				skid_sat_q <= sat_c;
			end else begin
				out_x_q   <= sx_c;
				out_y_q   <= sy_c;
				out_sat_q <= sat_c;
			end
		end else if (!result_stall) begin
			out_x_q   <= skid_x_q;
			out_y_q   <= skid_y_q;
			out_sat_q <= skid_sat_q;
		end
	end

	assign result_valid = out_vld_q;
	assign rotated_x    = out_x_q;
	assign rotated_y    = out_y_q;
	assign saturated    = out_sat_q;

`ifndef SYNTHESIS
	// A parked result always has a waiting result in front of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	// The skid register fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && result_stall))
		else $error("skid register filled without an output stall");

	// A clipped result sits at a range limit in at least one coordinate
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_sat_q) |->
			(out_x_q == OUT_HI || out_x_q == OUT_LO ||
			 out_y_q == OUT_HI || out_y_q == OUT_LO))
		else $error("saturated flag set without a clamped coordinate");

	// The pipeline stays frozen while a result is parked
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(vld_s6) && $stable(qx_s6) && $stable(qy_s6))
		else $error("last pipeline stage moved while frozen");
`endif

endmodule
